// ===== rtl/core/sbc_pkg.sv =====
// Shared constants, register codes and control bundle of the stereo bitcrusher.
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int MAX_DECIMATION_DEF = 64;

  // Configuration register widths
  localparam int DEC_W   = 7;
  localparam int DEPTH_W = 5;
  localparam int WET_W   = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL  = 2'd2;

  localparam logic [DEC_W-1:0]   DECIMATION_RST = 7'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_RST      = 5'd16;
  localparam logic [WET_W-1:0]   WET_RST        = 9'd0;
  localparam logic [WET_W-1:0]   WET_FULL       = 9'd256;

  // Per-cycle commands from the sequencer to both channel lanes
  typedef struct packed {
    logic               take;
    logic               capture;
    logic               level_en;
    logic               div_load;
    logic               div_step;
    logic               mix_load;
    logic               mul_step;
    logic               mul_bit;
    logic               finish;
    logic               quant_off;
    logic [DEPTH_W-1:0] bits;
  } sbc_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/sbc_ifs.sv =====
// Channel interfaces: input frame stream, result frame stream, register write port.
`timescale 1ns / 1ps
`default_nettype none
interface sbc_in_if #(
  parameter int W = sbc_pkg::SAMPLE_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] left_in;
  logic [W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sbc_out_if #(
  parameter int W = sbc_pkg::SAMPLE_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] left_out;
  logic [W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sbc_pkg::CFG_IDX_W-1:0]  index;
  logic [sbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/stereo_bitcrusher.sv =====
// Top level of the stereo bitcrusher: sample-and-hold decimator, bit crusher, dry/wet mix.
//
// Usage:
//   in_chan  - one stereo frame per beat (left_in, right_in, signed Q1.15).
//   out_chan - one mixed frame per input beat (left_out, right_out), saturated.
//   cfg_chan - register writes: index 0 decimation, 1 depth_bits, 2 wet_level.
//              Always ready; write only while no frame is in flight.
// Each frame is taken, then steps through level, divider load, division, mix load,
//   serial multiply and finish; the input is not ready until that frame has finished,
//   so the next frame waits. The bit-serial divider (one quotient bit per cycle) and
//   the serial wet multiply (one wet bit per cycle) set the frame rate.
// The output beat sits in a register, so the next frame is taken and processed
//   while a result waits; if the receiver stalls past that, the sequencer holds the
//   finished frame and the input stays not-ready until the output register frees.
// Reset (synchronous, active low) clears the phase counter and hold samples and
//   loads decimation 1, depth 16, wet 0: the block then passes frames unchanged.
//
`timescale 1ns / 1ps
`default_nettype none
module stereo_bitcrusher #(
  parameter int SAMPLE_WIDTH   = sbc_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_DECIMATION = sbc_pkg::MAX_DECIMATION_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbc_in_if.sink     in_chan,
  sbc_out_if.source  out_chan,
  sbc_cfg_if.sink    cfg_chan
);
  import sbc_pkg::*;

  // Shared control: both lanes step in lock-step off one sequencer
  sbc_ctrl_t ctrl;

  sbc_ctrl #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .MAX_DECIMATION (MAX_DECIMATION)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cfg_valid (cfg_chan.valid),
    .cfg_ready (cfg_chan.ready),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .ctrl      (ctrl)
  );

  // Left channel lane
  sbc_lane #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sample_in  (in_chan.left_in),
    .sample_out (out_chan.left_out)
  );

  // Right channel lane
  sbc_lane #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sample_in  (in_chan.right_in),
    .sample_out (out_chan.right_out)
  );

endmodule
`default_nettype wire

// ===== rtl/core/sbc_lane.sv =====
// One channel datapath: hold register, bit-serial quantizer divider, serial mixer.
`timescale 1ns / 1ps
`default_nettype none
module sbc_lane #(
  parameter int SAMPLE_WIDTH = sbc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sbc_pkg::sbc_ctrl_t      ctrl,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_in,
  output logic      [SAMPLE_WIDTH-1:0] sample_out
);
  import sbc_pkg::*;

  localparam int W      = SAMPLE_WIDTH;
  localparam int LVL_W  = W - 1;
  localparam int PROD_W = 2 * W;
  localparam int Q_W    = W + 1;
  localparam int DIFF_W = W + 2;
  localparam int ACC_W  = W + 10;
  localparam int SUM_W  = W + 11;
  localparam int RES_W  = SUM_W - 8;

  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (W - 1);
  localparam logic [Q_W-1:0]    HALF_Q = Q_W'(1) << (W - 1);
  localparam logic [SUM_W-1:0]  RND    = SUM_W'(128);
  localparam logic [W-1:0]      SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]      SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]      dry_r, held_r, out_r;
  logic [LVL_W-1:0]  level_r, rem_r;
  logic [W:0]        dsr_r;
  logic [Q_W-1:0]    q_r;
  logic [DIFF_W-1:0] diff_r;
  logic [ACC_W-1:0]  acc_r;

  logic [LVL_W-1:0]  steps;
  logic [W-1:0]      u;
  logic [PROD_W-1:0] prod;
  logic [LVL_W-1:0]  level_nxt;
  logic [W-1:0]      rem2, rem_sub;
  logic              ge;
  logic [LVL_W-1:0]  rem_nxt;
  logic [Q_W-1:0]    crushed;
  logic [DIFF_W-1:0] diff_nxt;
  logic [ACC_W-1:0]  acc_nxt;
  logic [SUM_W-1:0]  sum;
  logic [RES_W-1:0]  res;
  logic [W-1:0]      out_nxt;

  // steps = 2^bits - 1, level = (u*steps + half) >> W
  assign steps     = ~({LVL_W{1'b1}} << ctrl.bits);
  assign u         = {~held_r[W-1], held_r[W-2:0]};
  assign prod      = ({{W{1'b0}}, u} << ctrl.bits) - {{W{1'b0}}, u} + HALF_P;
  assign level_nxt = prod[W +: LVL_W];

  // Restoring division, one quotient bit per cycle
  assign rem2    = {rem_r, dsr_r[W]};
  assign ge      = (rem2 >= {1'b0, steps});
  assign rem_sub = rem2 - {1'b0, steps};
  assign rem_nxt = ge ? rem_sub[LVL_W-1:0] : rem2[LVL_W-1:0];

  assign crushed  = ctrl.quant_off ? {held_r[W-1], held_r} : (q_r - HALF_Q);
  assign diff_nxt = {crushed[Q_W-1], crushed} - {{2{dry_r[W-1]}}, dry_r};

  // Horner product, wet level MSB first
  assign acc_nxt = {acc_r[ACC_W-2:0], 1'b0}
                 + (ctrl.mul_bit ? {{(ACC_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r}
                                 : {ACC_W{1'b0}});

  assign sum = {acc_r[ACC_W-1], acc_r} + {{3{dry_r[W-1]}}, dry_r, 8'd0} + RND;
  assign res = sum[SUM_W-1:8];

  always_comb begin
    if ((res[RES_W-1:W-1] == '0) || (res[RES_W-1:W-1] == '1)) begin
      out_nxt = res[W-1:0];
    end else if (res[RES_W-1]) begin
      out_nxt = SAT_MIN;
    end else begin
      out_nxt = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (ctrl.capture) begin
      held_r <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      dry_r <= sample_in;
    end
    if (ctrl.level_en) begin
      level_r <= level_nxt;
    end
    if (ctrl.div_load) begin
      rem_r <= level_r >> 1;
      dsr_r <= {level_r[0], 1'b0, steps >> 1};
      q_r   <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= rem_nxt;
      dsr_r <= {dsr_r[W-1:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
    end
    if (ctrl.mix_load) begin
      diff_r <= diff_nxt;
      acc_r  <= '0;
    end else if (ctrl.mul_step) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.finish) begin
      out_r <= out_nxt;
    end
  end

  assign sample_out = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/sbc_ctrl.sv =====
// Sequencer: configuration registers, decimator phase, step counter and handshakes.
`timescale 1ns / 1ps
`default_nettype none
module sbc_ctrl #(
  parameter int SAMPLE_WIDTH   = sbc_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_DECIMATION = sbc_pkg::MAX_DECIMATION_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output sbc_pkg::sbc_ctrl_t                  ctrl
);
  import sbc_pkg::*;

  localparam int CNT_W  = $clog2(SAMPLE_WIDTH + 1);
  localparam int WIDX_W = $clog2(WET_W);
  localparam int DEC_TOP   = (1 << DEC_W) - 1;
  localparam int DEC_CLAMP = (MAX_DECIMATION < DEC_TOP) ? MAX_DECIMATION : DEC_TOP;
  localparam logic [DEC_W-1:0]   DEC_MAX   = DEC_W'(DEC_CLAMP);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(SAMPLE_WIDTH);
  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(SAMPLE_WIDTH);
  localparam logic [CNT_W-1:0]   MUL_LAST  = CNT_W'(WET_W - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LEVEL = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DIFF  = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DEC_W-1:0]   dec_r, phase_r, phase_nxt;
  logic [DEPTH_W-1:0] depth_r;
  logic [WET_W-1:0]   wet_r, wet_eff;
  logic [DEC_W-1:0]   dec_eff;
  logic [DEC_W:0]     phase_inc;
  logic               bypass, hit, take;
  logic [WIDX_W-1:0]  wet_idx;

  assign bypass = (dec_r <= DEC_W'(1)) && (depth_r >= DEPTH_MAX) && (wet_r == '0);
  assign dec_eff = (dec_r == '0) ? DEC_W'(1) : ((dec_r > DEC_MAX) ? DEC_MAX : dec_r);
  assign wet_eff = (wet_r > WET_FULL) ? WET_FULL : wet_r;
  assign phase_inc = {1'b0, phase_r} + (DEC_W+1)'(1);
  assign hit       = (phase_inc >= {1'b0, dec_eff});
  assign take      = in_valid && (state_r == ST_IDLE);
  assign wet_idx   = WIDX_W'(WET_W - 1) - cnt_r[WIDX_W-1:0];

  always_comb begin
    phase_nxt = phase_r;
    if (take && !bypass) begin
      phase_nxt = hit ? DEC_W'(phase_inc - {1'b0, dec_eff}) : phase_inc[DEC_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ctrl           = '0;
    ctrl.take      = take;
    ctrl.capture   = take && !bypass && hit;
    ctrl.quant_off = (depth_r >= DEPTH_MAX);
    ctrl.bits      = (depth_r == '0) ? DEPTH_W'(1) : depth_r;
    ctrl.mul_bit   = wet_eff[wet_idx];
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        ctrl.level_en = 1'b1;
        state_nxt     = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.div_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ctrl.mix_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul_step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          ctrl.finish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = ctrl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      dec_r       <= DECIMATION_RST;
      depth_r     <= DEPTH_RST;
      wet_r       <= WET_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_DECIMATION: dec_r   <= cfg_data[DEC_W-1:0];
          REG_DEPTH_BITS: depth_r <= cfg_data[DEPTH_W-1:0];
          REG_WET_LEVEL:  wet_r   <= cfg_data[WET_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

`ifndef SYNTH
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_ready)
    else $error("input still open after a beat was taken");
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.finish))
    else $error("output valid rose without a finished frame");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider step count out of range");
`endif

endmodule
`default_nettype wire
